FILE: sv/sinm_pkg.sv
// shared types and constants for the sorted insert nearest match unit
// no dependencies; every other file refers to it by scoped names

package sinm_pkg;

  localparam int CAPACITY = 1024;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ID_W     = 32;
  localparam int STR_W    = 30;

  localparam int IN_W    = 64;   // entry_id + strength, padded to bytes
  localparam int OUT_W   = 72;   // new_id + match_id + status, padded to bytes
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_SEED_ID       = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_STRENGTH = 1'b1;

  localparam logic [ID_W-1:0]  SEED_ID_RST  = 32'd1;
  localparam logic [STR_W-1:0] SEED_STR_RST = 30'd1000000000;

  localparam logic STATUS_STORED = 1'b0;
  localparam logic STATUS_FULL   = 1'b1;

  // one query travelling down the cell chain
  typedef struct packed {
    logic             vld;
    logic [ID_W-1:0]  id;
    logic [STR_W-1:0] str;
    logic [CNT_W-1:0] cnt;      // fill level seen when this beat entered
    logic             ins;      // store not full, entry gets inserted
    logic             le_has;   // strongest stored entry with strength <= str, newest of equals
    logic [ID_W-1:0]  le_id;
    logic [STR_W-1:0] le_str;
    logic             gt_has;   // weakest stored entry with strength > str, oldest of equals
    logic [ID_W-1:0]  gt_id;
    logic [STR_W-1:0] gt_str;
    logic [ID_W-1:0]  carry_id; // entry being shifted toward the tail
    logic [STR_W-1:0] carry_str;
  } tok_t;

endpackage

FILE: sv/sinm_cell.sv
// one slot of the ordered store: compares the passing query with its entry,
// collects neighbor candidates and shifts entries on insert; uses sinm_pkg

module sinm_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [sinm_pkg::CNT_W-1:0] idx,
  input  sinm_pkg::tok_t            tok_in,
  output sinm_pkg::tok_t            tok_out
);

  logic [sinm_pkg::ID_W-1:0]  slot_id;
  logic [sinm_pkg::STR_W-1:0] slot_str;
  logic                       occ;
  logic                       le;
  logic                       gt;
  logic                       wr;
  sinm_pkg::tok_t             tok_next;

  always_comb begin
    occ      = idx < tok_in.cnt;
    le       = slot_str <= tok_in.str;
    gt       = occ && !le;
    wr       = tok_in.vld && tok_in.ins && (gt || (idx == tok_in.cnt));
    tok_next = tok_in;
    if (occ && le) begin
      tok_next.le_has = 1'b1;
      tok_next.le_id  = slot_id;
      tok_next.le_str = slot_str;
    end
    if (gt && !tok_in.gt_has) begin
      tok_next.gt_has = 1'b1;
      tok_next.gt_id  = slot_id;
      tok_next.gt_str = slot_str;
    end
    // displaced entry moves on toward the tail
    if (gt && tok_in.ins) begin
      tok_next.carry_id  = slot_id;
      tok_next.carry_str = slot_str;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.vld <= 1'b0;
    end else if (en) begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en && wr) begin
      slot_id  <= tok_in.carry_id;
      slot_str <= tok_in.carry_str;
    end
  end

endmodule

FILE: sv/sinm_pick.sv
// tail of the chain: folds in the seed entry, picks the nearest neighbor
// and holds the result beat; uses sinm_pkg

module sinm_pick (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  sinm_pkg::tok_t              tok_in,
  input  logic [sinm_pkg::ID_W-1:0]   seed_id,
  input  logic [sinm_pkg::STR_W-1:0]  seed_str,
  output logic                        res_vld,
  output logic [sinm_pkg::ID_W-1:0]   res_new_id,
  output logic [sinm_pkg::ID_W-1:0]   res_match_id,
  output logic                        res_status
);

  typedef struct packed {
    logic                       vld;
    logic [sinm_pkg::ID_W-1:0]  id;
    logic [sinm_pkg::STR_W-1:0] str;
    logic                       status;
    logic                       has_prev;
    logic [sinm_pkg::ID_W-1:0]  prev_id;
    logic [sinm_pkg::STR_W-1:0] prev_str;
    logic                       has_next;
    logic [sinm_pkg::ID_W-1:0]  next_id;
    logic [sinm_pkg::STR_W-1:0] next_str;
  } sel_t;

  sel_t                       sel_next;
  sel_t                       sel;
  logic                       seed_le;
  logic [sinm_pkg::STR_W-1:0] d_prev;
  logic [sinm_pkg::STR_W-1:0] d_next;
  logic [sinm_pkg::ID_W-1:0]  match_next;

  // seed is oldest: it loses ties for prev and wins them for next
  always_comb begin
    seed_le           = seed_str <= tok_in.str;
    sel_next.vld      = tok_in.vld;
    sel_next.id       = tok_in.id;
    sel_next.str      = tok_in.str;
    sel_next.status   = tok_in.ins ? sinm_pkg::STATUS_STORED : sinm_pkg::STATUS_FULL;
    sel_next.has_prev = seed_le;
    sel_next.prev_id  = seed_id;
    sel_next.prev_str = seed_str;
    sel_next.has_next = !seed_le;
    sel_next.next_id  = seed_id;
    sel_next.next_str = seed_str;
    if (tok_in.le_has && (!seed_le || tok_in.le_str >= seed_str)) begin
      sel_next.has_prev = 1'b1;
      sel_next.prev_id  = tok_in.le_id;
      sel_next.prev_str = tok_in.le_str;
    end
    if (tok_in.gt_has && (seed_le || tok_in.gt_str < seed_str)) begin
      sel_next.has_next = 1'b1;
      sel_next.next_id  = tok_in.gt_id;
      sel_next.next_str = tok_in.gt_str;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel.vld <= 1'b0;
    end else if (en) begin
      sel <= sel_next;
    end
  end

  // equal distance goes to the weaker entry
  always_comb begin
    d_prev = sel.str - sel.prev_str;
    d_next = sel.next_str - sel.str;
    if (!sel.has_prev) begin
      match_next = sel.next_id;
    end else if (!sel.has_next) begin
      match_next = sel.prev_id;
    end else if (d_prev <= d_next) begin
      match_next = sel.prev_id;
    end else begin
      match_next = sel.next_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (en) begin
      res_vld <= sel.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_new_id   <= sel.id;
      res_match_id <= match_next;
      res_status   <= sel.status;
    end
  end

endmodule

FILE: sv/sorted_insert_nearest_match_unit.sv
// top level of the sorted insert nearest match unit: stream ports, seed
// registers, fill counter, the cell chain and the result stage; uses sinm_pkg

// The store is a row of CAPACITY cells, one stored entry each, kept in
// ascending strength order with the newest of equal strengths last. Every
// input beat becomes a query that walks the row one cell per cycle: each
// cell checks its entry against the query strength, remembers the strongest
// entry at or below it (newest of equals) and the weakest above it, and on
// insert swaps its entry with the one being carried, so the row stays
// sorted. Behind the last cell the permanent seed entry is folded in and
// the nearest neighbor is chosen (equal distance goes to the weaker entry).
// A new beat is taken every cycle; its result passes the cell, pick and
// result registers. Back-pressure on the result side holds the whole row,
// so input and output stall together. When the store is full the beat
// still gets its match but status reads full and nothing is stored. The
// seed registers are written through the config port and are read at the
// tail of the row, so they should only change while no beat is in flight.

module sorted_insert_nearest_match_unit (
  input  logic                             clk,
  input  logic                             rst,
  // input stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [sinm_pkg::IN_W-1:0]        s_tdata,   // entry_id[31:0], strength[61:32]
  // result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [sinm_pkg::OUT_W-1:0]       m_tdata,   // new_id[31:0], match_id[63:32],
                                                      // status[64]
  // config writes
  input  logic                             cfg_we,
  input  logic [sinm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sinm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic                        adv;
  logic                        accept;
  logic [sinm_pkg::CNT_W-1:0]  entry_count;
  logic [sinm_pkg::ID_W-1:0]   seed_id;
  logic [sinm_pkg::STR_W-1:0]  seed_str;
  logic                        not_full;
  sinm_pkg::tok_t              tok [0:sinm_pkg::CAPACITY];
  logic                        res_vld;
  logic [sinm_pkg::ID_W-1:0]   res_new_id;
  logic [sinm_pkg::ID_W-1:0]   res_match_id;
  logic                        res_status;

  // whole chain moves when the result register is free or being drained
  assign adv      = !res_vld || m_tready;
  assign s_tready = adv;
  assign accept   = s_tvalid && adv;
  assign not_full = entry_count != sinm_pkg::CNT_W'(sinm_pkg::CAPACITY);

  // seed registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_id  <= sinm_pkg::SEED_ID_RST;
      seed_str <= sinm_pkg::SEED_STR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sinm_pkg::CFG_SEED_ID:       seed_id  <= cfg_data;
        sinm_pkg::CFG_SEED_STRENGTH: seed_str <= cfg_data[sinm_pkg::STR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // fill level, counted as beats enter; each beat carries its own copy
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (accept && not_full) begin
      entry_count <= entry_count + 1'b1;
    end
  end

  // query built from the incoming beat
  always_comb begin
    tok[0]           = '0;
    tok[0].vld       = s_tvalid;
    tok[0].id        = s_tdata[sinm_pkg::ID_W-1:0];
    tok[0].str       = s_tdata[sinm_pkg::ID_W +: sinm_pkg::STR_W];
    tok[0].cnt       = entry_count;
    tok[0].ins       = not_full;
    tok[0].carry_id  = s_tdata[sinm_pkg::ID_W-1:0];
    tok[0].carry_str = s_tdata[sinm_pkg::ID_W +: sinm_pkg::STR_W];
  end

  // the row of store cells, slot k at position k
  for (genvar k = 0; k < sinm_pkg::CAPACITY; k++) begin : g_cell
    sinm_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (adv),
      .idx     (sinm_pkg::CNT_W'(k)),
      .tok_in  (tok[k]),
      .tok_out (tok[k+1])
    );
  end

  // seed merge, nearest pick and result register
  sinm_pick u_pick (
    .clk          (clk),
    .rst          (rst),
    .en           (adv),
    .tok_in       (tok[sinm_pkg::CAPACITY]),
    .seed_id      (seed_id),
    .seed_str     (seed_str),
    .res_vld      (res_vld),
    .res_new_id   (res_new_id),
    .res_match_id (res_match_id),
    .res_status   (res_status)
  );

  assign m_tvalid = res_vld;
  assign m_tdata  = {7'd0, res_status, res_match_id, res_new_id};

endmodule

FILE: dv/sorted_insert_nearest_match_unit_tb.sv
// testbench for sorted_insert_nearest_match_unit: a scoreboard class keeps its own
// ordered store and seed, predicts every nearest match and checks each result beat
// depends on sinm_pkg and the rtl of the unit

module sorted_insert_nearest_match_unit_tb;

  // the slowest correct run (1.3k beats, stall bursts on both sides, a full
  // row drain per phase) stays well under this limit, a wide margin
  localparam int unsigned               CYCLE_LIMIT = 300000;
  localparam logic [sinm_pkg::STR_W-1:0] STR_MAX    = '1;

  // one result beat, split into its fields
  typedef struct {
    bit [sinm_pkg::ID_W-1:0] new_id;
    bit [sinm_pkg::ID_W-1:0] match_id;
    bit                      status;
  } match_t;

  // mirror of the ordered store plus the seed; predicts the nearest match of
  // each accepted entry and holds the predictions until their beats arrive
  class nearest_match_board;
    bit [sinm_pkg::ID_W-1:0]  ids  [sinm_pkg::CAPACITY];
    bit [sinm_pkg::STR_W-1:0] strs [sinm_pkg::CAPACITY];
    int unsigned              fill;
    bit [sinm_pkg::ID_W-1:0]  seed_id;
    bit [sinm_pkg::STR_W-1:0] seed_str;
    match_t                   awaited[$];
    int unsigned              errors;

    function new();
      seed_id  = sinm_pkg::SEED_ID_RST;
      seed_str = sinm_pkg::SEED_STR_RST;
      fill     = 0;
      errors   = 0;
    endfunction

    function void load_seed_reg(logic [sinm_pkg::CFG_IDX_W-1:0] idx,
                                logic [sinm_pkg::CFG_DATA_W-1:0] data);
      if (idx == sinm_pkg::CFG_SEED_ID) begin
        seed_id = data;
      end else if (idx == sinm_pkg::CFG_SEED_STRENGTH) begin
        seed_str = data[sinm_pkg::STR_W-1:0];
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // nearest match of a new entry, then insertion behind its equals
    function void add_entry(bit [sinm_pkg::ID_W-1:0] id, bit [sinm_pkg::STR_W-1:0] str);
      int unsigned              pos;
      bit                       has_lo;
      bit                       has_hi;
      bit [sinm_pkg::ID_W-1:0]  lo_id;
      bit [sinm_pkg::ID_W-1:0]  hi_id;
      bit [sinm_pkg::STR_W-1:0] lo_str;
      bit [sinm_pkg::STR_W-1:0] hi_str;
      match_t                   want;
      pos = 0;
      while (pos < fill && strs[pos] <= str) pos++;
      has_lo = 1'b0;
      has_hi = 1'b0;
      lo_id  = '0;
      hi_id  = '0;
      lo_str = '0;
      hi_str = '0;
      // the seed is the oldest entry: it loses ties below, wins ties above
      if (seed_str <= str) begin
        has_lo = 1'b1;
        lo_id  = seed_id;
        lo_str = seed_str;
      end else begin
        has_hi = 1'b1;
        hi_id  = seed_id;
        hi_str = seed_str;
      end
      if (pos > 0 && (!has_lo || strs[pos-1] >= lo_str)) begin
        has_lo = 1'b1;
        lo_id  = ids[pos-1];
        lo_str = strs[pos-1];
      end
      if (pos < fill && (!has_hi || strs[pos] < hi_str)) begin
        has_hi = 1'b1;
        hi_id  = ids[pos];
        hi_str = strs[pos];
      end
      want.new_id = id;
      if (!has_lo) begin
        want.match_id = hi_id;
      end else if (!has_hi) begin
        want.match_id = lo_id;
      end else begin
        // equal distance goes to the weaker neighbor
        want.match_id = (str - lo_str <= hi_str - str) ? lo_id : hi_id;
      end
      if (fill >= sinm_pkg::CAPACITY) begin
        want.status = sinm_pkg::STATUS_FULL;
      end else begin
        for (int i = fill; i > pos; i--) begin
          ids[i]  = ids[i-1];
          strs[i] = strs[i-1];
        end
        ids[pos]    = id;
        strs[pos]   = str;
        fill++;
        want.status = sinm_pkg::STATUS_STORED;
      end
      awaited.push_back(want);
    endfunction

    task check_match(match_t got);
      match_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result beat new_id %h with no entry pending", got.new_id));
        return;
      end
      want = awaited.pop_front();
      if (got.new_id != want.new_id)
        report($sformatf("new_id %h, predicted %h", got.new_id, want.new_id));
      if (got.match_id != want.match_id)
        report($sformatf("new_id %h: match_id %h, predicted %h",
                         want.new_id, got.match_id, want.match_id));
      if (got.status != want.status)
        report($sformatf("new_id %h: status %0d, predicted %0d",
                         want.new_id, got.status, want.status));
    endtask
  endclass

  logic                            clk;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [sinm_pkg::IN_W-1:0]       s_tdata;
  logic                            m_tvalid;
  logic                            m_tready;
  logic [sinm_pkg::OUT_W-1:0]      m_tdata;
  logic                            cfg_we;
  logic [sinm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [sinm_pkg::CFG_DATA_W-1:0] cfg_data;

  nearest_match_board       board;
  match_t                   seen_beat;
  bit [sinm_pkg::STR_W-1:0] recent_strs[$];   // recent strengths, reused to make duplicates
  int                       idle_pct = 0;     // chance of an idle burst on either side

  sorted_insert_nearest_match_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // every handshake and register write is seen here at the rising edge;
  // inputs only move on the falling edge, so the sampled values are settled
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we)
        board.load_seed_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready)
        board.add_entry(s_tdata[sinm_pkg::ID_W-1:0],
                        s_tdata[sinm_pkg::ID_W +: sinm_pkg::STR_W]);
      if (m_tvalid && m_tready) begin
        seen_beat.new_id   = m_tdata[sinm_pkg::ID_W-1:0];
        seen_beat.match_id = m_tdata[sinm_pkg::ID_W +: sinm_pkg::ID_W];
        seen_beat.status   = m_tdata[2*sinm_pkg::ID_W];
        board.check_match(seen_beat);
      end
    end
  end

  // result side: random stall bursts of random length
  initial begin
    m_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (!rst && $urandom_range(0, 99) < idle_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  // cycle counter; a run that hangs ends here
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  function automatic bit [sinm_pkg::ID_W-1:0] pick_id();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // strength mix: full range, a coarse grid near zero and near the top (dense
  // ties and equal distances), values around the seed, extremes, repeats
  function automatic bit [sinm_pkg::STR_W-1:0] pick_strength();
    longint near;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) begin
      return sinm_pkg::STR_W'($urandom_range(0, STR_MAX));
    end else if (roll < 45) begin
      return sinm_pkg::STR_W'($urandom_range(0, 63) * 4);
    end else if (roll < 55) begin
      return sinm_pkg::STR_W'(STR_MAX - $urandom_range(0, 31) * 4);
    end else if (roll < 72) begin
      near = longint'(board.seed_str) + $urandom_range(0, 12) - 6;
      if (near < 0) near = 0;
      if (near > STR_MAX) near = STR_MAX;
      return sinm_pkg::STR_W'(near);
    end else if (roll < 82) begin
      case ($urandom_range(0, 3))
        0:       return '0;
        1:       return sinm_pkg::STR_W'(1);
        2:       return STR_MAX - 1'b1;
        default: return STR_MAX;
      endcase
    end else if (recent_strs.size() > 0) begin
      return recent_strs[$urandom_range(0, recent_strs.size() - 1)];
    end else begin
      return sinm_pkg::STR_W'($urandom_range(0, STR_MAX));
    end
  endfunction

  // one input beat, after an optional idle burst; returns once accepted
  task automatic send_entry(input bit [sinm_pkg::ID_W-1:0] id,
                            input bit [sinm_pkg::STR_W-1:0] str);
    @(negedge clk);
    if ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(sinm_pkg::IN_W - sinm_pkg::ID_W - sinm_pkg::STR_W){1'b0}}, str, id};
    recent_strs.push_back(str);
    if (recent_strs.size() > 16) void'(recent_strs.pop_front());
    do @(posedge clk); while (!s_tready);
  endtask

  // stop sending and wait until every predicted result has come back;
  // each entry gives exactly one result, so nothing is left in the row then
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic set_seed_reg(input logic [sinm_pkg::CFG_IDX_W-1:0] idx,
                              input logic [sinm_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    board     = new();
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_we    = 1'b0;
    cfg_index = sinm_pkg::CFG_SEED_ID;
    cfg_data  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part, seed still at its reset values
    idle_pct = 25;
    send_entry(32'h0000_0000, 30'd1000000000);  // equal to seed: seed is the lower side
    send_entry(32'hFFFF_FFFF, 30'd1000000000);  // newest of the equals wins below
    send_entry(32'h0000_0010, 30'd0);           // seed wins ties above
    send_entry(32'h0000_0011, STR_MAX);
    send_entry(32'h0000_0012, 30'd1);
    send_entry(32'h0000_0013, 30'd100);
    send_entry(32'h0000_0014, 30'd200);
    send_entry(32'h0000_0015, 30'd150);         // equal distance goes to the weaker
    send_entry(32'h0000_0016, 30'd150);
    send_entry(32'h0000_0017, 30'd150);
    send_entry(32'h0000_0018, 30'd999999999);
    send_entry(32'h0000_0019, 30'd1000000001);
    send_entry(32'h0000_001a, 30'd500000000);
    send_entry(32'h5555_5555, 30'h2AAA_AAAA);
    send_entry(32'hAAAA_AAAA, 30'h1555_5555);
    send_entry(32'h0000_001b, STR_MAX - 1'b1);
    send_entry(32'h0000_001c, STR_MAX);
    send_entry(32'h0000_001d, 30'd0);
    send_entry(32'h0000_001e, 30'd175);         // tie between 150 and 200
    drain();

    // random phases, each with its own seed; the store fills up early in the
    // last phase, which then runs with it full
    for (int ph = 1; ph <= 5; ph++) begin
      case (ph)
        1: begin
          // zero seed; the two top data bits must be dropped
          set_seed_reg(sinm_pkg::CFG_SEED_ID, 32'h0000_0000);
          set_seed_reg(sinm_pkg::CFG_SEED_STRENGTH, 32'hC000_0000);
          idle_pct = 30;
        end
        2: begin
          set_seed_reg(sinm_pkg::CFG_SEED_ID, 32'hFFFF_FFFF);
          set_seed_reg(sinm_pkg::CFG_SEED_STRENGTH, 32'h3FFF_FFFF);
          idle_pct = 0;
        end
        3: begin
          set_seed_reg(sinm_pkg::CFG_SEED_ID, $urandom());
          set_seed_reg(sinm_pkg::CFG_SEED_STRENGTH, $urandom());
          idle_pct = 50;
        end
        4: begin
          set_seed_reg(sinm_pkg::CFG_SEED_STRENGTH, $urandom_range(0, 4096));
          set_seed_reg(sinm_pkg::CFG_SEED_ID, $urandom());
          idle_pct = 15;
        end
        default: begin
          set_seed_reg(sinm_pkg::CFG_SEED_ID, $urandom());
          set_seed_reg(sinm_pkg::CFG_SEED_STRENGTH, $urandom());
          idle_pct = 30;
        end
      endcase
      for (int n = 0; n < 250; n++) begin
        // the closing stretch runs at full rate on both sides
        if (ph == 5 && n >= 130) idle_pct = 0;
        send_entry(pick_id(), pick_strength());
      end
      drain();
    end

    // a full row length more, so a stray extra beat would still show up
    repeat (sinm_pkg::CAPACITY + 16) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/sinm_pkg.sv
sv/sinm_cell.sv
sv/sinm_pick.sv
sv/sorted_insert_nearest_match_unit.sv
dv/sorted_insert_nearest_match_unit_tb.sv
